// ===== design/dstf_pkg.sv =====
package dstf_pkg;

  localparam int DEF_FRACTION_BITS       = 24;
  localparam int DEF_INTEGER_BITS        = 32;
  localparam int DEF_MAX_FRACTION_DIGITS = 8;

  localparam int DECIMAL_BASE = 10;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_INVALID   = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_t;

  // Error flags that travel with a finished number.
  typedef struct packed {
    logic bad;
    logic overflow;
  } parse_flags_t;

  // Elaboration-time power of ten, used to build the fraction weight table.
  function automatic longint unsigned pow10(input int k);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < k; i++) begin
      p = p * longint'(DECIMAL_BASE);
    end
    return p;
  endfunction

endpackage

// ===== design/dstf_accum.sv =====
module dstf_accum import dstf_pkg::*; #(
  parameter int FRACTION_BITS       = DEF_FRACTION_BITS,
  parameter int INTEGER_BITS        = DEF_INTEGER_BITS,
  parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic [7:0]               item_char,
  input  logic                     item_last,
  output logic                     done_valid,
  input  logic                     done_ready,
  output logic [INTEGER_BITS-1:0]  done_integer,
  output logic [FRACTION_BITS:0]   done_fraction,
  output parse_flags_t             done_flags
);

  localparam int POS_W = $clog2(MAX_FRACTION_DIGITS + 1);
  localparam int PROD_W = INTEGER_BITS + 4;
  localparam int TERM_W = FRACTION_BITS + 4;

  // Weight of a fraction digit at position k: 2^FRACTION_BITS / 10^k, rounded.
  logic [FRACTION_BITS-1:0] weight [0:MAX_FRACTION_DIGITS];

  assign weight[0] = '0;

  for (genvar k = 1; k <= MAX_FRACTION_DIGITS; k++) begin : g_weight
    localparam longint unsigned P10 = pow10(k);
    localparam longint unsigned W = ((64'd1 << FRACTION_BITS) + P10 / 2) / P10;
    assign weight[k] = FRACTION_BITS'(W);
  end

  logic [INTEGER_BITS-1:0]  integer_sum, integer_sum_next;
  logic [FRACTION_BITS:0]   fraction_sum, fraction_sum_next;
  logic [POS_W-1:0]         fraction_position, fraction_position_next;
  logic                     in_fraction, in_fraction_next;
  logic                     bad_seen, bad_seen_next;
  logic                     overflow_seen, overflow_seen_next;

  logic                     is_digit;
  logic                     is_separator;
  logic [3:0]               digit;
  logic [PROD_W-1:0]        int_product;
  logic [POS_W-1:0]         pos_inc;
  logic [TERM_W-1:0]        frac_term;
  logic                     done_load;
  logic                     consume;

  assign is_digit     = item_char inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_separator = item_char inside {CHAR_DOT, CHAR_COMMA};
  assign digit        = 4'(item_char - CHAR_ZERO);

  // Times ten as two shifts, plus the new digit.
  assign int_product = (PROD_W'(integer_sum) << 3) + (PROD_W'(integer_sum) << 1)
                     + PROD_W'(digit);
  assign pos_inc     = fraction_position + POS_W'(1);
  assign frac_term   = TERM_W'(digit) * TERM_W'(weight[pos_inc]);

  always_comb begin
    integer_sum_next       = integer_sum;
    fraction_sum_next      = fraction_sum;
    fraction_position_next = fraction_position;
    in_fraction_next       = in_fraction;
    bad_seen_next          = bad_seen;
    overflow_seen_next     = overflow_seen;
    if (is_digit) begin
      if (!in_fraction) begin
        if (|int_product[PROD_W-1:INTEGER_BITS]) begin
          integer_sum_next   = '1;
          overflow_seen_next = 1'b1;
        end else begin
          integer_sum_next = int_product[INTEGER_BITS-1:0];
        end
      end else if (fraction_position < POS_W'(MAX_FRACTION_DIGITS)) begin
        // Digits past the last weighted position are dropped.
        fraction_position_next = pos_inc;
        fraction_sum_next      = fraction_sum + frac_term[FRACTION_BITS:0];
      end
    end else if (is_separator && !in_fraction) begin
      in_fraction_next = 1'b1;
    end else begin
      bad_seen_next = 1'b1;
    end
  end

  assign done_load  = !done_valid || done_ready;
  assign item_ready = !item_last || done_load;
  assign consume    = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      integer_sum       <= '0;
      fraction_sum      <= '0;
      fraction_position <= '0;
      in_fraction       <= 1'b0;
      bad_seen          <= 1'b0;
      overflow_seen     <= 1'b0;
      done_valid        <= 1'b0;
    end else begin
      if (consume && item_last) begin
        integer_sum       <= '0;
        fraction_sum      <= '0;
        fraction_position <= '0;
        in_fraction       <= 1'b0;
        bad_seen          <= 1'b0;
        overflow_seen     <= 1'b0;
        done_valid        <= 1'b1;
      end else begin
        if (consume) begin
          integer_sum       <= integer_sum_next;
          fraction_sum      <= fraction_sum_next;
          fraction_position <= fraction_position_next;
          in_fraction       <= in_fraction_next;
          bad_seen          <= bad_seen_next;
          overflow_seen     <= overflow_seen_next;
        end
        if (done_ready) begin
          done_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && item_last) begin
      done_integer        <= integer_sum_next;
      done_fraction       <= fraction_sum_next;
      done_flags.bad      <= bad_seen_next;
      done_flags.overflow <= overflow_seen_next;
    end
  end

endmodule

// ===== design/decimal_string_to_fixed_top.sv =====
// Parses a decimal number sent one ASCII character per word, with last marking
// the final character, into an unsigned fixed-point value with INTEGER_BITS
// integer and FRACTION_BITS fraction bits, plus a status (ok, invalid character,
// integer part saturated). One character is taken every clock cycle unless the
// finished number is stalled; the result word appears once the last character
// has passed the input register, the accumulator stage and the output register.
// The cycle time is set by the accumulator stage: one multiply-by-ten and add with
// a saturation check on the integer part, or one digit-times-weight product and
// add on the fraction part. Fraction digits past MAX_FRACTION_DIGITS are
// checked but ignored.
module decimal_string_to_fixed_top import dstf_pkg::*; #(
  parameter int FRACTION_BITS       = DEF_FRACTION_BITS,
  parameter int INTEGER_BITS        = DEF_INTEGER_BITS,
  parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  char_valid,
  output logic                                  char_ready,
  input  logic [7:0]                            character,
  input  logic                                  last,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic [INTEGER_BITS+FRACTION_BITS-1:0] value,
  output logic [1:0]                            status
);

  localparam int VALUE_W = INTEGER_BITS + FRACTION_BITS;

  logic                     in_full;
  logic [7:0]               in_char;
  logic                     in_last;
  logic                     acc_ready;

  logic                     done_valid;
  logic                     done_ready;
  logic [INTEGER_BITS-1:0]  done_integer;
  logic [FRACTION_BITS:0]   done_fraction;
  parse_flags_t             done_flags;

  logic [INTEGER_BITS:0]    total;
  logic [VALUE_W-1:0]       value_next;
  status_t                  status_next;

  assign char_ready = !in_full || acc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_ready) begin
      in_full <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      in_char <= character;
      in_last <= last;
    end
  end

  dstf_accum #(
    .FRACTION_BITS       (FRACTION_BITS),
    .INTEGER_BITS        (INTEGER_BITS),
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (in_full),
    .item_ready    (acc_ready),
    .item_char     (in_char),
    .item_last     (in_last),
    .done_valid    (done_valid),
    .done_ready    (done_ready),
    .done_integer  (done_integer),
    .done_fraction (done_fraction),
    .done_flags    (done_flags)
  );

  // The fraction weights may round up past one; that carry joins the integer.
  assign total = (INTEGER_BITS + 1)'(done_integer)
               + (INTEGER_BITS + 1)'(done_fraction[FRACTION_BITS]);

  always_comb begin
    if (done_flags.bad) begin
      value_next  = '0;
      status_next = STATUS_INVALID;
    end else if (done_flags.overflow || total[INTEGER_BITS]) begin
      value_next  = '1;
      status_next = STATUS_SATURATED;
    end else begin
      value_next  = {total[INTEGER_BITS-1:0], done_fraction[FRACTION_BITS-1:0]};
      status_next = STATUS_OK;
    end
  end

  assign done_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done_ready) begin
      result_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      value  <= value_next;
      status <= status_next;
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == STATUS_OK || status == STATUS_INVALID ||
                      status == STATUS_SATURATED))
    else $error("result word carries an undefined status code");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == STATUS_INVALID) |-> (value == '0))
    else $error("invalid-character result has a nonzero value");

  a_saturated_ones: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == STATUS_SATURATED) |-> (&value))
    else $error("saturated result is not all ones");

  a_last_needs_room: assert property (@(posedge clk) disable iff (rst)
    (in_full && in_last && done_valid && !done_ready) |-> !acc_ready)
    else $error("final character consumed while the finished number is stalled");

endmodule
